### hdl/kmrd_pkg.sv
// shared types and constants for the key matrix row debouncer
package kmrd_pkg;

	localparam int ROW_W         = 2;
	localparam int COLS_W        = 11;
	localparam int HOLD_W        = 8;
	localparam int TOTAL_W       = 6;
	localparam int NUM_ROWS_DEF  = 4;
	localparam int NUM_COLS_DEF  = 11;

	localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd3;
	localparam logic [TOTAL_W-1:0] PRESSED_MAX = 6'd63;

	typedef struct packed {
		logic [ROW_W-1:0]  row_index;
		logic [COLS_W-1:0] raw_columns;
	} in_t;

	typedef struct packed {
		logic [ROW_W-1:0]   row_out;
		logic [COLS_W-1:0]  stable_state;
		logic [COLS_W-1:0]  prior_state;
		logic [COLS_W-1:0]  changed_bits;
		logic [TOTAL_W-1:0] pressed_total;
	} out_t;

endpackage

### hdl/key_matrix_row_debouncer_top.sv
// key matrix row debouncer: per-key hold-off counters and running pressed count
//
// Takes one scanned matrix row per request and returns one result per request,
// one row per clock cycle sustained unless out_stall holds the output, with the
// result registered after the input register. The input register feeds a single
// pass of per-column logic (counter test, state select, counter reload) whose
// outcome is written into the row's state and counters and into the output
// register at the same edge, so a scan of the same row in the next cycle
// already sees the update. The matrix-wide pressed count is a running total
// adjusted by each row's change, saturating at 63 on the output. Rows at or
// above NUM_ROWS change nothing and report zero row states. Column bits at or
// above NUM_COLS (or above bit 10) are ignored. The hold setting hold_q is written
// through cfg_we/cfg_data and resets to 3.
module key_matrix_row_debouncer_top #(
	parameter int NUM_ROWS = kmrd_pkg::NUM_ROWS_DEF,
	parameter int NUM_COLS = kmrd_pkg::NUM_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  kmrd_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output kmrd_pkg::out_t              out_data,
	input  logic                        cfg_we,
	input  logic [kmrd_pkg::HOLD_W-1:0] cfg_data
);

	localparam int EFF_COLS = (NUM_COLS < kmrd_pkg::COLS_W) ? NUM_COLS : kmrd_pkg::COLS_W;
	localparam int MAX_KEYS = NUM_ROWS * EFF_COLS;
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int SAT_W    = (CNT_W > kmrd_pkg::TOTAL_W) ? CNT_W : kmrd_pkg::TOTAL_W;

	logic [kmrd_pkg::HOLD_W-1:0] hold_q;
	logic                        valid_s1;
	kmrd_pkg::in_t               data_s1;
	logic                        out_valid_q;
	kmrd_pkg::out_t              out_q;
	logic [CNT_W-1:0]            total_q;

	logic [kmrd_pkg::HOLD_W-1:0] cnt_q [NUM_ROWS][EFF_COLS];
	logic [EFF_COLS-1:0]         state_q [NUM_ROWS];

	logic                        out_load;
	logic                        advance;
	logic [NUM_ROWS-1:0]         hit;
	logic                        in_range;
	logic [kmrd_pkg::HOLD_W-1:0] cnt_sel [EFF_COLS];
	logic [kmrd_pkg::HOLD_W-1:0] cnt_new [EFF_COLS];
	logic [EFF_COLS-1:0]         prior;
	logic [EFF_COLS-1:0]         open_cols;
	logic [EFF_COLS-1:0]         stable;
	logic [EFF_COLS-1:0]         changed;
	logic [CNT_W-1:0]            total_next;
	logic [SAT_W-1:0]            total_ext;
	kmrd_pkg::out_t              result;

	assign out_load  = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !out_load;
	assign advance   = valid_s1 && out_load;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// one-hot row select, rows past NUM_ROWS never hit
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			hit[r] = (int'(data_s1.row_index) == r);
		end
		in_range = |hit;
	end

	always_comb begin
		prior = '0;
		for (int c = 0; c < EFF_COLS; c++) begin
			cnt_sel[c] = '0;
		end
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (hit[r]) begin
				prior = prior | state_q[r];
				for (int c = 0; c < EFF_COLS; c++) begin
					cnt_sel[c] = cnt_sel[c] | cnt_q[r][c];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < EFF_COLS; c++) begin
			open_cols[c] = (cnt_sel[c] == '0);
		end
		stable  = (data_s1.raw_columns[EFF_COLS-1:0] & open_cols) | (prior & ~open_cols);
		changed = stable ^ prior;
		for (int c = 0; c < EFF_COLS; c++) begin
			if (changed[c]) begin
				cnt_new[c] = hold_q;
			end else if (open_cols[c]) begin
				cnt_new[c] = '0;
			end else begin
				cnt_new[c] = cnt_sel[c] - 1'b1;
			end
		end
	end

	// running total moves by the row's change in pressed keys
	always_comb begin
		if (in_range) begin
			total_next = total_q + CNT_W'($countones(stable)) - CNT_W'($countones(prior));
		end else begin
			total_next = total_q;
		end
		total_ext = SAT_W'(total_next);

		result.row_out      = data_s1.row_index;
		result.stable_state = in_range ? kmrd_pkg::COLS_W'(stable) : '0;
		result.prior_state  = in_range ? kmrd_pkg::COLS_W'(prior) : '0;
		result.changed_bits = in_range ? kmrd_pkg::COLS_W'(changed) : '0;
		if (total_ext > SAT_W'(kmrd_pkg::PRESSED_MAX)) begin
			result.pressed_total = kmrd_pkg::PRESSED_MAX;
		end else begin
			result.pressed_total = total_ext[kmrd_pkg::TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= kmrd_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			hold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int r = 0; r < NUM_ROWS; r++) begin
				state_q[r] <= '0;
				for (int c = 0; c < EFF_COLS; c++) begin
					cnt_q[r][c] <= '0;
				end
			end
		end else if (advance) begin
			total_q <= total_next;
			for (int r = 0; r < NUM_ROWS; r++) begin
				if (hit[r]) begin
					state_q[r] <= stable;
					for (int c = 0; c < EFF_COLS; c++) begin
						cnt_q[r][c] <= cnt_new[c];
					end
				end
			end
		end
	end

`ifndef SYNTH
	// running total can never pass the number of keys in the matrix
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_KEYS))
		else $error("pressed total exceeds key count");

	// input side only stalls while a request sits in the input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked request");

	// a result for an unknown row carries no row state
	a_bad_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !in_range) |=> out_q.stable_state == '0 && out_q.prior_state == '0)
		else $error("out-of-range row reported state");

	// the reported changed bits always equal the xor of the stable and prior states
	a_change_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.changed_bits == (out_data.stable_state ^ out_data.prior_state))
		else $error("changed bits disagree with states");
`endif

endmodule

### tb/tb_key_matrix_row_debouncer_top.sv
// testbench for the key matrix row debouncer: random row scans checked against a debounce predictor
module tb_key_matrix_row_debouncer_top;

	localparam int ROWS       = kmrd_pkg::NUM_ROWS_DEF;
	localparam int COLS       = kmrd_pkg::NUM_COLS_DEF;
	localparam int LONG_HOLD  = 60;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE     = 8;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	kmrd_pkg::in_t                 in_data   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	kmrd_pkg::out_t                out_data;
	logic                          cfg_we    = 1'b0;
	logic [kmrd_pkg::HOLD_W-1:0]   cfg_data  = '0;

	// predictor copy of the block state
	logic [kmrd_pkg::HOLD_W-1:0]   hold_setting = kmrd_pkg::HOLD_RESET;
	logic [kmrd_pkg::HOLD_W-1:0]   hold_cnt [ROWS][COLS] = '{default: '0};
	logic [kmrd_pkg::COLS_W-1:0]   row_bits [ROWS] = '{default: '0};

	kmrd_pkg::in_t                 scan_q[$];
	kmrd_pkg::out_t                due_results[$];

	// intended key positions used to build realistic scan sequences
	logic [kmrd_pkg::COLS_W-1:0]   held_keys [ROWS] = '{default: '0};
	int                            scan_row     = 0;

	int                            tx_idle_pct  = 0;
	int                            rx_stall_pct = 0;
	logic                          long_hold_arm = 1'b0;
	int                            hold_off_cnt = 0;
	int                            idle_cycles  = 0;

	int                            errors       = 0;
	int                            scans_sent   = 0;
	int                            results_seen = 0;
	int                            key_changes  = 0;
	int                            settings_used = 1;

	key_matrix_row_debouncer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic kmrd_pkg::out_t debounce_row(kmrd_pkg::in_t s);
		kmrd_pkg::out_t                r;
		logic [kmrd_pkg::COLS_W-1:0]   open_mask;
		logic [kmrd_pkg::COLS_W-1:0]   before_bits;
		logic [kmrd_pkg::COLS_W-1:0]   after_bits;
		int                            total;
		before_bits = '0;
		after_bits  = '0;
		open_mask   = '0;
		if (s.row_index < ROWS) begin
			before_bits = row_bits[s.row_index];
			for (int c = 0; c < COLS; c++) begin
				if (hold_cnt[s.row_index][c] != 0)
					hold_cnt[s.row_index][c] = hold_cnt[s.row_index][c] - 1'b1;
				else
					open_mask[c] = 1'b1;
			end
			after_bits = (s.raw_columns & open_mask) | (before_bits & ~open_mask);
			for (int c = 0; c < COLS; c++) begin
				if (after_bits[c] != before_bits[c])
					hold_cnt[s.row_index][c] = hold_setting;
			end
			row_bits[s.row_index] = after_bits;
		end
		total = 0;
		for (int rr = 0; rr < ROWS; rr++)
			total += $countones(row_bits[rr]);
		r.row_out       = s.row_index;
		r.stable_state  = after_bits;
		r.prior_state   = before_bits;
		r.changed_bits  = after_bits ^ before_bits;
		r.pressed_total = (total > kmrd_pkg::PRESSED_MAX) ? kmrd_pkg::PRESSED_MAX :
			kmrd_pkg::TOTAL_W'(total);
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// driver: a request holds until accepted, then the next one may follow
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (scan_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_data  <= scan_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off when armed
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold_arm && hold_off_cnt < LONG_HOLD) begin
				out_stall    <= 1'b1;
				hold_off_cnt <= hold_off_cnt + 1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		kmrd_pkg::out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing pending: expected none actual %h",
						$time, out_data);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("row_out", 16'(want.row_out), 16'(out_data.row_out));
					check_field("stable_state", 16'(want.stable_state),
						16'(out_data.stable_state));
					check_field("prior_state", 16'(want.prior_state),
						16'(out_data.prior_state));
					check_field("changed_bits", 16'(want.changed_bits),
						16'(out_data.changed_bits));
					check_field("pressed_total", 16'(want.pressed_total),
						16'(out_data.pressed_total));
					key_changes += $countones(want.changed_bits);
				end
			end
			if (cfg_we)
				hold_setting = cfg_data;
			if (in_valid && !in_stall) begin
				scans_sent++;
				due_results.push_back(debounce_row(in_data));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_scan(int unsigned row, int unsigned cols);
		kmrd_pkg::in_t s;
		s.row_index   = row[kmrd_pkg::ROW_W-1:0];
		s.raw_columns = cols[kmrd_pkg::COLS_W-1:0];
		scan_q.push_back(s);
	endtask

	// mostly rows scanned in order with slowly changing keys and contact bounce,
	// the rest fully random or extreme patterns
	task automatic add_random_scans(int n);
		int unsigned                   pick;
		logic [kmrd_pkg::COLS_W-1:0]   bounce;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				if ($urandom_range(9) == 0)
					held_keys[scan_row][$urandom_range(COLS - 1)] ^= 1'b1;
				if ($urandom_range(49) == 0)
					held_keys[scan_row] = kmrd_pkg::COLS_W'($urandom);
				bounce = '0;
				if ($urandom_range(4) == 0)
					bounce[$urandom_range(COLS - 1)] = 1'b1;
				add_scan(scan_row, held_keys[scan_row] ^ bounce);
				scan_row = (scan_row + 1) % ROWS;
			end else if (pick < 92) begin
				add_scan($urandom_range(ROWS - 1), $urandom);
			end else begin
				add_scan($urandom_range(ROWS - 1), $urandom_range(1) ? 'h7FF : 'h000);
			end
		end
	endtask

	task automatic write_hold(int unsigned v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v[kmrd_pkg::HOLD_W-1:0];
		@(posedge clk);
		cfg_we   <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_drained();
		while (scan_q.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(int tx_pct, int rx_pct);
		@(posedge clk);
		tx_idle_pct  <= tx_pct;
		rx_stall_pct <= rx_pct;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed scans at the reset hold of three
		add_scan(0, 'h7FF);
		add_scan(0, 'h000);
		add_scan(0, 'h000);
		add_scan(0, 'h000);
		add_scan(0, 'h000);
		add_scan(0, 'h000);
		add_scan(1, 'h555);
		add_scan(2, 'h2AA);
		add_scan(3, 'h7FF);
		add_scan(1, 'h2AA);
		add_scan(3, 'h000);
		add_scan(1, 'h2AA);
		add_scan(2, 'h001);
		add_scan(2, 'h400);
		add_scan(1, 'h2AA);
		add_scan(2, 'h400);
		add_scan(3, 'h000);
		add_scan(3, 'h000);
		add_scan(2, 'h401);
		add_scan(3, 'h7FF);
		add_scan(0, 'h7FF);
		wait_drained();

		// zero hold: every change is visible on the very next scan
		write_hold(0);
		set_idling(65, 0);
		add_scan(0, 'h7FF);
		add_scan(0, 'h000);
		add_scan(0, 'h7FF);
		add_random_scans(260);
		wait_drained();

		// largest hold: keys stay frozen for a long time
		write_hold(255);
		set_idling(0, 65);
		add_random_scans(260);
		wait_drained();

		write_hold(1);
		set_idling(15, 15);
		add_random_scans(260);
		wait_drained();

		// full-rate requests against a long receiver hold-off, then a sender pause
		write_hold($urandom_range(2, 12));
		set_idling(0, 0);
		@(posedge clk);
		long_hold_arm <= 1'b1;
		add_random_scans(130);
		wait_drained();
		add_random_scans(130);
		wait_drained();

		write_hold($urandom_range(2, 12));
		set_idling(30, 30);
		add_random_scans(536);
		wait_drained();

		repeat (SETTLE) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: %0d results never arrived, next expected %h", $time,
				due_results.size(), due_results[0]);
			errors++;
		end
		$display("run covered %0d row scans and %0d results over %0d hold settings",
			scans_sent, results_seen, settings_used);
		$display("debounced key changes observed: %0d, mismatches: %0d", key_changes, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/kmrd_pkg.sv
hdl/key_matrix_row_debouncer_top.sv
tb/tb_key_matrix_row_debouncer_top.sv
